FILE: rtl/ries_pkg.sv
// ----------------------------------------------------------------------------
// ries_pkg
// Shared types, constants and helpers for the range-of-interval-sums engine.
// ----------------------------------------------------------------------------
package ries_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int POS_W      = 11;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 64;

    // command codes
    localparam logic [1:0] CMD_SET_VALUE = 2'd0;
    localparam logic [1:0] CMD_QUERY     = 2'd1;
    localparam logic [1:0] CMD_SET_IVL   = 2'd2;

    // request from the sequencer to the storage
    typedef struct packed {
        logic              val_we;
        logic [ADDR_W-1:0] val_waddr;
        logic [VAL_W-1:0]  val_wdata;
        logic [ADDR_W-1:0] val_raddr;
        logic              ivl_we;
        logic [ADDR_W-1:0] ivl_waddr;
        logic [POS_W-1:0]  ivl_wstart;
        logic [POS_W-1:0]  ivl_wend;
        logic [ADDR_W-1:0] ivl_raddr;
        logic              pre_we;
        logic [ADDR_W-1:0] pre_waddr;
        logic [SUM_W-1:0]  pre_wdata;
        logic [ADDR_W-1:0] pre_raddr;
    } mem_req_t;

    // registered read data
    typedef struct packed {
        logic [VAL_W-1:0] val_rdata;
        logic [POS_W-1:0] ivl_rstart;
        logic [POS_W-1:0] ivl_rend;
        logic [SUM_W-1:0] pre_rdata;
    } mem_rsp_t;

    // clamp a position into [1, hi]
    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v,
                                                    input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] r;
        begin
            if (v == '0)
                r = POS_W'(1);
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

FILE: rtl/ries_store.sv
// ----------------------------------------------------------------------------
// ries_store
// Value, interval and prefix-sum memories with registered read ports.
// ----------------------------------------------------------------------------
module ries_store
(
    input  logic              clk,
    input  ries_pkg::mem_req_t req,
    output ries_pkg::mem_rsp_t rsp
);

    logic [ries_pkg::VAL_W-1:0] val_mem   [ries_pkg::MAX_LENGTH];
    logic [ries_pkg::POS_W-1:0] start_mem [ries_pkg::MAX_LENGTH];
    logic [ries_pkg::POS_W-1:0] end_mem   [ries_pkg::MAX_LENGTH];
    logic [ries_pkg::SUM_W-1:0] pre_mem   [ries_pkg::MAX_LENGTH];

    // values, intervals and prefix sums: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.val_waddr] <= req.val_wdata;
        end
        if (req.ivl_we)
        begin
            start_mem[req.ivl_waddr] <= req.ivl_wstart;
            end_mem[req.ivl_waddr]   <= req.ivl_wend;
        end
        if (req.pre_we)
        begin
            pre_mem[req.pre_waddr] <= req.pre_wdata;
        end
        rsp.val_rdata  <= val_mem[req.val_raddr];
        rsp.ivl_rstart <= start_mem[req.ivl_raddr];
        rsp.ivl_rend   <= end_mem[req.ivl_raddr];
        rsp.pre_rdata  <= pre_mem[req.pre_raddr];
    end

endmodule

FILE: rtl/range_of_interval_sums_engine.sv
// ----------------------------------------------------------------------------
// range_of_interval_sums_engine
// Value array plus per-function intervals; answers range queries of worths.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one command request; s_tready is high only while the
//   engine is idle. Set-value and set-interval requests finish in the cycle
//   they are accepted and give no result. A query gives one 64-bit total on
//   m_tdata.
//   A query first builds the prefix sums over the first length_in_use values,
//   reading each value through the single value read port and accumulating
//   it, then takes each function's worth in range through the single prefix
//   read port: it reads the interval, adds the upper prefix sum, subtracts
//   the lower prefix sum and moves on to the next function.
//   The result stays in the output register until m_tready takes it; no new
//   request is accepted meanwhile.
//   After reset a clearing pass over all MAX_LENGTH (1024) entries sets all values
//   to zero and all intervals to [1,1]; s_tready stays low during it.
//   length_in_use is written through cfg_we/cfg_wdata, by the user only while
//   idle (the block does not enforce it); 0 reads as 1, values above 1024 as 1024. Reset value is 1024.
// ----------------------------------------------------------------------------
module range_of_interval_sums_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], target[12:2], new_value[44:13], range_low[55:45],
    // range_high[66:56], zero[71:67]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // total[63:0]
    output logic [63:0] m_tdata
);

    localparam int AW = ries_pkg::ADDR_W;
    localparam int PW = ries_pkg::POS_W;
    localparam int SW = ries_pkg::SUM_W;
    localparam logic [PW-1:0] MAX_POS = PW'(ries_pkg::MAX_LENGTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_P_RD, ST_P_ACC, ST_F_RD, ST_F_CHK,
        ST_F_HI, ST_F_LO, ST_F_NEXT, ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [PW-1:0]    len_reg, len_next;
    logic [PW-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]    qlo_reg, qlo_next;
    logic [PW-1:0]    qhi_reg, qhi_next;
    logic [PW-1:0]    s_reg, s_next;
    logic [SW-1:0]    acc_reg, acc_next;
    logic [SW-1:0]    tot_reg, tot_next;

    ries_pkg::mem_req_t req;
    ries_pkg::mem_rsp_t rsp;

    // request fields
    logic [1:0]     in_cmd;
    logic [PW-1:0]  in_target;
    logic [31:0]    in_value;
    logic [PW-1:0]  in_rlo;
    logic [PW-1:0]  in_rhi;
    logic           in_fire;
    logic           target_ok;
    logic [SW-1:0]  pre_sum;
    logic [PW-1:0]  f_hi;

    assign in_cmd    = s_tdata[1:0];
    assign in_target = s_tdata[12:2];
    assign in_value  = s_tdata[44:13];
    assign in_rlo    = s_tdata[55:45];
    assign in_rhi    = s_tdata[66:56];

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = tot_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign target_ok = (in_target != '0) && (in_target <= len_reg);

    assign pre_sum = acc_reg + {{(SW-32){rsp.val_rdata[31]}}, rsp.val_rdata};
    assign f_hi    = (rsp.ivl_rend > len_reg) ? len_reg : rsp.ivl_rend;

    ries_store u_store
    (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        qlo_next   = qlo_reg;
        qhi_next   = qhi_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        tot_next   = tot_reg;

        req            = '0;
        req.val_raddr  = cnt_reg[AW-1:0];
        req.pre_waddr  = cnt_reg[AW-1:0];
        req.pre_wdata  = pre_sum;
        req.ivl_raddr  = AW'(cnt_reg - PW'(1));

        if (cfg_we)
        begin
            len_next = ries_pkg::clamp_pos(cfg_wdata, MAX_POS);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                req.val_we     = 1'b1;
                req.val_waddr  = cnt_reg[AW-1:0];
                req.val_wdata  = '0;
                req.ivl_we     = 1'b1;
                req.ivl_waddr  = cnt_reg[AW-1:0];
                req.ivl_wstart = PW'(1);
                req.ivl_wend   = PW'(1);
                if (cnt_reg == MAX_POS - PW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + PW'(1);
                end
            end
            ST_IDLE:
            begin
                req.val_waddr  = AW'(in_target - PW'(1));
                req.val_wdata  = in_value;
                req.ivl_waddr  = AW'(in_target - PW'(1));
                req.ivl_wstart = ries_pkg::clamp_pos(in_rlo, MAX_POS);
                req.ivl_wend   = ries_pkg::clamp_pos(in_rhi, MAX_POS);
                if (in_fire)
                begin
                    case (in_cmd)
                        ries_pkg::CMD_SET_VALUE: req.val_we = target_ok;
                        ries_pkg::CMD_SET_IVL:   req.ivl_we = target_ok;
                        ries_pkg::CMD_QUERY:
                        begin
                            qlo_next   = ries_pkg::clamp_pos(in_rlo, len_reg);
                            qhi_next   = ries_pkg::clamp_pos(in_rhi, len_reg);
                            acc_next   = '0;
                            tot_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_P_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_P_RD:
            begin
                state_next = ST_P_ACC;
            end
            ST_P_ACC:
            begin
                req.pre_we = 1'b1;
                acc_next   = pre_sum;
                if (cnt_reg == len_reg - PW'(1))
                begin
                    if (qlo_reg > qhi_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cnt_next   = qlo_reg;
                        state_next = ST_F_RD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + PW'(1);
                    state_next = ST_P_RD;
                end
            end
            ST_F_RD:
            begin
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                // reversed or fully beyond length: worth zero
                req.pre_raddr = AW'(f_hi - PW'(1));
                s_next        = rsp.ivl_rstart;
                if ((rsp.ivl_rstart > rsp.ivl_rend) || (rsp.ivl_rstart > f_hi))
                    state_next = ST_F_NEXT;
                else
                    state_next = ST_F_HI;
            end
            ST_F_HI:
            begin
                req.pre_raddr = AW'(s_reg - PW'(2));
                tot_next      = tot_reg + rsp.pre_rdata;
                if (s_reg == PW'(1))
                    state_next = ST_F_NEXT;
                else
                    state_next = ST_F_LO;
            end
            ST_F_LO:
            begin
                tot_next   = tot_reg - rsp.pre_rdata;
                state_next = ST_F_NEXT;
            end
            ST_F_NEXT:
            begin
                if (cnt_reg == qhi_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next   = cnt_reg + PW'(1);
                    state_next = ST_F_RD;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            len_reg   <= MAX_POS;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        qlo_reg <= qlo_next;
        qhi_reg <= qhi_next;
        s_reg   <= s_next;
        acc_reg <= acc_next;
        tot_reg <= tot_next;
    end

endmodule

FILE: dv/ries_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ries_checker
// Watches the request, total and register channels of the range-of-interval-
// sums engine, keeps its own copy of the values and intervals, predicts each
// query total and compares it with the total that the engine returns.
// ----------------------------------------------------------------------------
module ries_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // cmd[1:0], target[12:2], new_value[44:13], range_low[55:45],
    // range_high[66:56], zero[71:67]
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // total[63:0]
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          totals_pending,
    output int          requests_seen,
    output int          totals_seen
);

    logic [63:0]               value_mem [1:ries_pkg::MAX_LENGTH];
    logic [ries_pkg::POS_W-1:0] ivl_start [1:ries_pkg::MAX_LENGTH];
    logic [ries_pkg::POS_W-1:0] ivl_end   [1:ries_pkg::MAX_LENGTH];
    logic [63:0]               prefix    [0:ries_pkg::MAX_LENGTH];
    logic [ries_pkg::POS_W-1:0] cur_length;
    logic [63:0]               expected_totals [$];

    function automatic logic [ries_pkg::POS_W-1:0] clip_pos(
        input logic [ries_pkg::POS_W-1:0] v,
        input logic [ries_pkg::POS_W-1:0] hi);
        if (v == '0)
            return ries_pkg::POS_W'(1);
        if (v > hi)
            return hi;
        return v;
    endfunction

    // sum of function worths over a clamped function range
    function automatic logic [63:0] predict_total(
        input logic [ries_pkg::POS_W-1:0] lo_in,
        input logic [ries_pkg::POS_W-1:0] hi_in);
        logic [ries_pkg::POS_W-1:0] lo;
        logic [ries_pkg::POS_W-1:0] hi;
        logic [ries_pkg::POS_W-1:0] a;
        logic [ries_pkg::POS_W-1:0] b;
        logic [63:0]               acc;
        int                        i;
        prefix[0] = '0;
        for (i = 1; i <= cur_length; i++)
            prefix[i] = prefix[i-1] + value_mem[i];
        lo  = clip_pos(lo_in, cur_length);
        hi  = clip_pos(hi_in, cur_length);
        acc = '0;
        for (i = lo; i <= hi; i++)
        begin
            a = ivl_start[i];
            b = ivl_end[i];
            if (b > cur_length)
                b = cur_length;
            if (a <= b)
                acc = acc + (prefix[b] - prefix[a-1]);
        end
        return acc;
    endfunction

    assign totals_pending = expected_totals.size();

    // request side: update the model, queue expected totals
    always @(posedge clk or negedge rst_n)
    begin : req_side
        logic [1:0]                cmd;
        logic [ries_pkg::POS_W-1:0] tgt;
        logic [31:0]               nv;
        logic [ries_pkg::POS_W-1:0] rlo;
        logic [ries_pkg::POS_W-1:0] rhi;
        if (!rst_n)
        begin
            for (int i = 1; i <= ries_pkg::MAX_LENGTH; i++)
            begin
                value_mem[i] = '0;
                ivl_start[i] = ries_pkg::POS_W'(1);
                ivl_end[i]   = ries_pkg::POS_W'(1);
            end
            cur_length    = ries_pkg::POS_W'(ries_pkg::MAX_LENGTH);
            requests_seen = 0;
        end
        else
        begin
            if (cfg_we)
                cur_length = clip_pos(cfg_wdata,
                                      ries_pkg::POS_W'(ries_pkg::MAX_LENGTH));
            if (s_tvalid && s_tready)
            begin
                cmd = s_tdata[1:0];
                tgt = s_tdata[12:2];
                nv  = s_tdata[44:13];
                rlo = s_tdata[55:45];
                rhi = s_tdata[66:56];
                requests_seen++;
                if (cmd == ries_pkg::CMD_SET_VALUE)
                begin
                    if (tgt >= 1 && tgt <= cur_length)
                        value_mem[tgt] = {{32{nv[31]}}, nv};
                end
                else if (cmd == ries_pkg::CMD_SET_IVL)
                begin
                    if (tgt >= 1 && tgt <= cur_length)
                    begin
                        ivl_start[tgt] = clip_pos(rlo,
                                         ries_pkg::POS_W'(ries_pkg::MAX_LENGTH));
                        ivl_end[tgt]   = clip_pos(rhi,
                                         ries_pkg::POS_W'(ries_pkg::MAX_LENGTH));
                    end
                end
                else if (cmd == ries_pkg::CMD_QUERY)
                    expected_totals.push_back(predict_total(rlo, rhi));
            end
        end
    end

    // result side: compare with the oldest expected total
    always @(posedge clk or negedge rst_n)
    begin : rsp_side
        logic [63:0] want;
        if (!rst_n)
        begin
            fail_count  = 0;
            totals_seen = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            totals_seen++;
            if (expected_totals.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected total %h", $realtime, m_tdata);
            end
            else
            begin
                want = expected_totals.pop_front();
                if (want !== m_tdata)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: total mismatch exp %h got %h",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the range-of-interval-sums engine: directed edge requests,
// then random command streams over several length settings, with random
// gaps on both channels. The checker predicts and compares every total.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 50000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          fail_count;
    int          totals_pending;
    int          requests_seen;
    int          totals_seen;
    int          cycle_count = 0;
    int          cur_len;
    int          out_stall;

    range_of_interval_sums_engine uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ries_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .totals_pending(totals_pending),
        .requests_seen(requests_seen), .totals_seen(totals_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result-side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            out_stall <= 0;
        end
        else if (out_stall > 0)
        begin
            m_tready  <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            m_tready  <= 1'b1;
            out_stall <= pick_gap();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [71:0] pack_req(input logic [1:0] cmd,
                                             input logic [10:0] tgt,
                                             input logic [31:0] nv,
                                             input logic [10:0] rlo,
                                             input logic [10:0] rhi);
        return {5'b0, rhi, rlo, nv, tgt, cmd};
    endfunction

    // one request; entered and left at a rising edge
    task automatic send_req(input logic [71:0] req, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // wait until every total is back, then let the engine settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (totals_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_length(input logic [10:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_len = (v == 11'd0) ? 1 :
                  ((int'(v) > ries_pkg::MAX_LENGTH) ? ries_pkg::MAX_LENGTH : int'(v));
        @(posedge clk);
    endtask

    function automatic logic [10:0] pick_pos(input int len);
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 11'($urandom_range(1, len));
        if (r < 90)
            return 11'd0;
        if (r < 95)
            return 11'($urandom_range(len, len + 3));
        return 11'($urandom);
    endfunction

    function automatic logic [71:0] random_req(input int len);
        int          r;
        logic [1:0]  cmd;
        logic [10:0] a;
        logic [10:0] b;
        r = $urandom_range(99);
        if (r < 40)
            cmd = ries_pkg::CMD_SET_VALUE;
        else if (r < 70)
            cmd = ries_pkg::CMD_SET_IVL;
        else if (r < 95)
            cmd = ries_pkg::CMD_QUERY;
        else
            cmd = CMD_UNUSED;
        a = pick_pos(len);
        b = pick_pos(len);
        // keep most intervals and ranges in order
        if ($urandom_range(9) < 8 && a > b)
            {a, b} = {b, a};
        return pack_req(cmd, pick_pos(len), 32'($urandom), a, b);
    endfunction

    task automatic directed_reqs();
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'd1, 32'h8000_0000, 11'd0, 11'd0), 0);
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'd1024, 32'h7fff_ffff, 11'd0, 11'd0), 0);
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'd2, 32'hffff_ffff, 11'd0, 11'd0), 1);
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'd0, 32'h1234_5678, 11'd0, 11'd0), 0);
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'h7ff, 32'h1234_5678, 11'd0, 11'd0), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd1, 11'd1), 0);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'd1, 32'd0, 11'd0, 11'd1024), 0);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'd2, 32'd0, 11'd1000, 11'h7ff), 0);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'd3, 32'd0, 11'd9, 11'd4), 0);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'd1024, 32'd0, 11'd1024, 11'd1024), 2);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'd0, 32'd0, 11'd1, 11'd2), 0);
        send_req(pack_req(ries_pkg::CMD_SET_IVL, 11'h7ff, 32'd0, 11'd1, 11'd2), 0);
        send_req(pack_req(CMD_UNUSED, 11'd1, 32'hffff_ffff, 11'd1, 11'd3), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd0, 11'd3), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd5, 11'd2), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd1020, 11'h7ff), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd0, 11'h7ff), 0);
        write_length(11'd3);
        // intervals now reach past the length in use
        send_req(pack_req(ries_pkg::CMD_SET_VALUE, 11'd4, 32'd5, 11'd0, 11'd0), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd1, 11'h7ff), 0);
        send_req(pack_req(ries_pkg::CMD_QUERY, 11'd0, 32'd0, 11'd3, 11'd3), 0);
    endtask

    initial
    begin : stimulus
        int lengths [10];
        int counts  [10];
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cur_len     = ries_pkg::MAX_LENGTH;
        lengths = '{1024, 1, 2, 0, 16, 37, 64, 2047, 8, 100};
        counts  = '{60, 100, 100, 60, 250, 250, 250, 40, 150, 140};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_reqs();
        for (int p = 0; p < 10; p++)
        begin
            write_length(11'(lengths[p]));
            for (int k = 0; k < counts[p]; k++)
            begin
                // hold off until all totals are back
                if (p == 5 && k == 120)
                    drain();
                send_req(random_req(cur_len), (p == 4) ? 0 : pick_gap());
            end
        end
        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d requests over the reset length and 11 length writes; %0d totals checked.",
                 requests_seen, totals_seen);
        if (fail_count == 0 && totals_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
